FILE: hw/rtl/vfc_pkg.sv
// Shared types and constants for the voxel face culler.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package vfc_pkg;

   localparam int DEF_CHUNK_WIDTH = 16;
   localparam int DEF_CHUNK_TALL  = 256;
   localparam int DEF_TYPE_BITS   = 8;

   localparam int COUNT_BITS  = 19;
   localparam int VERTEX_BITS = 21;
   localparam int NUM_DIRS    = 6;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_EMIT  = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      DIR_TOP    = 3'd0,
      DIR_BOTTOM = 3'd1,
      DIR_RIGHT  = 3'd2,
      DIR_LEFT   = 3'd3,
      DIR_FRONT  = 3'd4,
      DIR_BACK   = 3'd5
   } face_dir_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LAST,
      ST_EMIT
   } ctrl_state_type;

   // Control strobes of the cell store ports.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   // One face record as it leaves the sequencer.
   typedef struct packed {
      logic [3:0]             x;
      logic [7:0]             y;
      logic [3:0]             z;
      face_dir_type           dir;
      logic [7:0]             block;
      logic [VERTEX_BITS-1:0] base;
      logic                   last;
   } face_type;

endpackage

`default_nettype wire

FILE: hw/rtl/vfc_cell_mem.sv
// Cell store: one write port and one read port, read data registered.
// Depends on vfc_pkg for the port control struct.
`default_nettype none

module vfc_cell_mem #(
   parameter int DEPTH     = 65536,
   parameter int ADDR_BITS = 16,
   parameter int DATA_BITS = 9
) (
   input  wire                     clock,
   input  vfc_pkg::mem_ctl_type    mem_ctl,
   input  wire   [ADDR_BITS-1:0]   wr_addr,
   input  wire   [DATA_BITS-1:0]   wr_data,
   input  wire   [ADDR_BITS-1:0]   rd_addr,
   output logic  [DATA_BITS-1:0]   rd_data
);
   import vfc_pkg::*;

   logic [DATA_BITS-1:0] store_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data <= store_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/vfc_mesh_ctrl.sv
// Request sequencer: store writes, the seven reads of a mesh request, face count
// and face selection. Depends on vfc_pkg.
`default_nettype none

module vfc_mesh_ctrl #(
   parameter int CHUNK_WIDTH = 16,
   parameter int CHUNK_TALL  = 256,
   parameter int TYPE_BITS   = 8,
   parameter int ADDR_BITS   = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire                          req_func,
   input  wire   [3:0]                  req_cell_x,
   input  wire   [7:0]                  req_cell_y,
   input  wire   [3:0]                  req_cell_z,
   input  wire                          req_cell_active,
   input  wire   [7:0]                  req_cell_type,
   input  wire                          req_restart_mesh,
   output vfc_pkg::mem_ctl_type         mem_ctl,
   output logic  [ADDR_BITS-1:0]        wr_addr,
   output logic  [TYPE_BITS:0]          wr_data,
   output logic  [ADDR_BITS-1:0]        rd_addr,
   input  wire   [TYPE_BITS:0]          rd_data,
   output logic                         face_emit,
   output vfc_pkg::face_type            face
);
   import vfc_pkg::*;

   localparam int WIDE_BITS = TYPE_BITS + 8;
   localparam logic [2:0] LAST_IDX = 3'(NUM_DIRS);

   ctrl_state_type          state_ff, state_in;
   logic [3:0]              x_ff, x_in;
   logic [7:0]              y_ff, y_in;
   logic [3:0]              z_ff, z_in;
   logic [2:0]              rd_idx_ff, rd_idx_in;
   logic [2:0]              chk_idx_ff;
   logic                    chk_vld_ff;
   logic                    act_ff;
   logic [TYPE_BITS-1:0]    type_ff;
   logic [NUM_DIRS-1:0]     open_ff;
   logic [NUM_DIRS-1:0]     mask_ff, mask_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;

   logic                    req_in_chunk;
   logic                    accept;
   logic [NUM_DIRS-1:0]     oob;
   logic [4:0]              nx;
   logic [8:0]              ny;
   logic [4:0]              nz;
   logic [WIDE_BITS-1:0]    type_wide_wr;
   logic [WIDE_BITS-1:0]    type_wide_rd;
   logic [NUM_DIRS-1:0]     emit_mask;
   logic [2:0]              sel_dir;

   assign req_in_chunk = (32'(req_cell_x) < CHUNK_WIDTH) && (32'(req_cell_y) < CHUNK_TALL)
                         && (32'(req_cell_z) < CHUNK_WIDTH);
   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Writes go straight to the store in the cycle they are taken.
   assign type_wide_wr = WIDE_BITS'(req_cell_type);
   assign wr_data      = {req_cell_active, type_wide_wr[TYPE_BITS-1:0]};
   assign wr_addr      = ADDR_BITS'((32'(req_cell_x) * CHUNK_TALL + 32'(req_cell_y))
                                    * CHUNK_WIDTH + 32'(req_cell_z));

   // Neighbors that fall off the chunk are always open; their read goes to the cell itself and is ignored.
   assign oob[DIR_TOP]    = (32'(y_ff) + 32'd1) >= CHUNK_TALL;
   assign oob[DIR_BOTTOM] = (y_ff == 8'd0);
   assign oob[DIR_RIGHT]  = (32'(x_ff) + 32'd1) >= CHUNK_WIDTH;
   assign oob[DIR_LEFT]   = (x_ff == 4'd0);
   assign oob[DIR_FRONT]  = (32'(z_ff) + 32'd1) >= CHUNK_WIDTH;
   assign oob[DIR_BACK]   = (z_ff == 4'd0);

   // Read address: the cell itself at index zero, then one neighbor per index.
   always_comb begin
      nx = 5'(x_ff);
      ny = 9'(y_ff);
      nz = 5'(z_ff);
      if (rd_idx_ff != 3'd0) begin
         unique case (face_dir_type'(rd_idx_ff - 3'd1))
            DIR_TOP:    ny = 9'(y_ff) + 9'd1;
            DIR_BOTTOM: ny = 9'(y_ff) - 9'd1;
            DIR_RIGHT:  nx = 5'(x_ff) + 5'd1;
            DIR_LEFT:   nx = 5'(x_ff) - 5'd1;
            DIR_FRONT:  nz = 5'(z_ff) + 5'd1;
            DIR_BACK:   nz = 5'(z_ff) - 5'd1;
            default: ;
         endcase
         if (oob[rd_idx_ff - 3'd1]) begin
            nx = 5'(x_ff);
            ny = 9'(y_ff);
            nz = 5'(z_ff);
         end
      end
      rd_addr = ADDR_BITS'((32'(nx) * CHUNK_TALL + 32'(ny)) * CHUNK_WIDTH + 32'(nz));
   end

   // Lowest open face goes first.
   always_comb begin
      emit_mask = mask_ff;
      sel_dir   = 3'd0;
      for (int i = NUM_DIRS - 1; i >= 0; i--) begin
         if (emit_mask[i]) begin
            sel_dir = 3'(i);
         end
      end
   end

   assign type_wide_rd = WIDE_BITS'(type_ff);

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      rd_idx_in     = rd_idx_ff;
      mask_in       = mask_ff;
      count_in      = count_ff;
      mem_ctl.wr_en = 1'b0;
      mem_ctl.rd_en = 1'b0;
      face_emit     = 1'b0;
      face.x        = x_ff;
      face.y        = y_ff;
      face.z        = z_ff;
      face.dir      = face_dir_type'(sel_dir);
      face.block    = type_wide_rd[7:0];
      face.base     = {count_ff, 2'b00};
      face.last     = ((mask_ff & (mask_ff - 6'd1)) == '0);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_in_chunk) begin
               if (req_func == FUNC_WRITE) begin
                  mem_ctl.wr_en = 1'b1;
               end else begin
                  state_in  = ST_READ;
                  x_in      = req_cell_x;
                  y_in      = req_cell_y;
                  z_in      = req_cell_z;
                  rd_idx_in = 3'd0;
                  if (req_restart_mesh) begin
                     count_in = '0;
                  end
               end
            end
         end
         ST_READ: begin
            mem_ctl.rd_en = 1'b1;
            rd_idx_in     = rd_idx_ff + 3'd1;
            if (rd_idx_ff == LAST_IDX) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            // The back neighbor is still on the read port, so its flag is taken live.
            state_in          = ST_EMIT;
            mask_in           = open_ff;
            mask_in[DIR_BACK] = oob[DIR_BACK] | ~rd_data[TYPE_BITS];
         end
         ST_EMIT: begin
            if (!act_ff || mask_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               face_emit = 1'b1;
               count_in  = count_ff + 19'd1;
               mask_in   = mask_ff & (mask_ff - 6'd1);
               if (face.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         chk_vld_ff <= mem_ctl.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      rd_idx_ff  <= rd_idx_in;
      mask_ff    <= mask_in;
      chk_idx_ff <= rd_idx_ff;
      if (chk_vld_ff) begin
         if (chk_idx_ff == 3'd0) begin
            act_ff  <= rd_data[TYPE_BITS];
            type_ff <= rd_data[TYPE_BITS-1:0];
         end else begin
            open_ff[chk_idx_ff - 3'd1] <= oob[chk_idx_ff - 3'd1] | ~rd_data[TYPE_BITS];
         end
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/voxel_face_culler_core.sv
// Voxel face culler top level: chunk cell store, request sequencer, result register.
// Depends on vfc_pkg, vfc_cell_mem and vfc_mesh_ctrl.
// A mesh request steps through ST_READ, with seven reads through the single store read port,
// then ST_LAST and ST_EMIT, which releases the visible faces in turn to the result register.
// Busy holds from the taken request until ST_EMIT returns to idle; writes go back to back.
// Reset clears the sequencer and the face count; the store contents stay undefined until written.
`default_nettype none

module voxel_face_culler_core #(
   parameter int CHUNK_WIDTH = vfc_pkg::DEF_CHUNK_WIDTH,
   parameter int CHUNK_TALL  = vfc_pkg::DEF_CHUNK_TALL,
   parameter int TYPE_BITS   = vfc_pkg::DEF_TYPE_BITS
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   output logic         busy,
   input  wire          req_func,
   input  wire   [3:0]  req_cell_x,
   input  wire   [7:0]  req_cell_y,
   input  wire   [3:0]  req_cell_z,
   input  wire          req_cell_active,
   input  wire   [7:0]  req_cell_type,
   input  wire          req_restart_mesh,
   output logic         rsp_strobe,
   output logic  [3:0]  rsp_face_x,
   output logic  [7:0]  rsp_face_y,
   output logic  [3:0]  rsp_face_z,
   output logic  [2:0]  rsp_face_dir,
   output logic  [7:0]  rsp_face_block,
   output logic  [20:0] rsp_base_vertex,
   output logic         rsp_last_face
);
   import vfc_pkg::*;

   // The store holds one word per cell: the active flag above the block type.
   localparam int DEPTH     = CHUNK_WIDTH * CHUNK_TALL * CHUNK_WIDTH;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int DATA_BITS = TYPE_BITS + 1;

   mem_ctl_type            mem_ctl;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [DATA_BITS-1:0]   wr_data;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic [DATA_BITS-1:0]   rd_data;
   logic                   face_emit;
   face_type               face;

   logic                   rsp_strobe_ff;
   face_type               rsp_face_ff;

   // All requests pass through the sequencer. Writes land in the store in the
   // cycle they are taken; a mesh request reads its cell and six neighbors
   // back to back, then releases one face per cycle.
   vfc_mesh_ctrl #(
      .CHUNK_WIDTH (CHUNK_WIDTH),
      .CHUNK_TALL  (CHUNK_TALL),
      .TYPE_BITS   (TYPE_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_cell_z       (req_cell_z),
      .req_cell_active  (req_cell_active),
      .req_cell_type    (req_cell_type),
      .req_restart_mesh (req_restart_mesh),
      .mem_ctl          (mem_ctl),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .face_emit        (face_emit),
      .face             (face)
   );

   // Writes happen only while the sequencer is idle and reads only while it is
   // busy, so no access to one cell can overlap another.
   vfc_cell_mem #(
      .DEPTH     (DEPTH),
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result register. The strobe is the only reset bit; the record is payload.
   // It lets the next request be taken while the final face is still shown.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= face_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (face_emit) begin
         rsp_face_ff <= face;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_face_x      = rsp_face_ff.x;
   assign rsp_face_y      = rsp_face_ff.y;
   assign rsp_face_z      = rsp_face_ff.z;
   assign rsp_face_dir    = rsp_face_ff.dir;
   assign rsp_face_block  = rsp_face_ff.block;
   assign rsp_base_vertex = rsp_face_ff.base;
   assign rsp_last_face   = rsp_face_ff.last;

   // A face only ever follows a cycle in which a mesh request was in progress.
   a_strobe_from_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("face result without a request in progress");

   // Faces of one cell come on consecutive cycles, in direction order, four vertices apart.
   a_face_sequence: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_face |=> rsp_strobe
         && (rsp_face_dir > $past(rsp_face_dir))
         && (rsp_base_vertex == 21'($past(rsp_base_vertex) + 21'd4)))
      else $error("faces of one cell out of sequence");

   // The final face of a cell is followed by a gap.
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_face |=> !rsp_strobe)
      else $error("face result right after the final face of a cell");

   // A store write never occupies the sequencer.
   a_write_no_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_func == FUNC_WRITE) |=> !busy)
      else $error("write request left the block busy");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking bench for voxel_face_culler_core: fills parts of the chunk store, meshes cells
// and checks every face record against a behavioral mirror of the store and the face counter.
// Depends on vfc_pkg and the voxel_face_culler_core RTL; reads no files.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vfc_pkg::*;

   localparam int CELLS      = DEF_CHUNK_WIDTH * DEF_CHUNK_TALL * DEF_CHUNK_WIDTH;
   localparam int SETTLE_CYC = 32;  // covers the wait for the first face plus a full mesh
   localparam int MAX_SHOWN  = 10;

   // One face record as the bench expects it on the response port.
   typedef struct packed {
      logic [3:0]             x;
      logic [7:0]             y;
      logic [3:0]             z;
      face_dir_type           dir;
      logic [7:0]             block;
      logic [VERTEX_BITS-1:0] base;
      logic                   last;
   } face_record_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_func;
   logic [3:0]  req_cell_x;
   logic [7:0]  req_cell_y;
   logic [3:0]  req_cell_z;
   logic        req_cell_active;
   logic [7:0]  req_cell_type;
   logic        req_restart_mesh;
   logic        rsp_strobe;
   logic [3:0]  rsp_face_x;
   logic [7:0]  rsp_face_y;
   logic [3:0]  rsp_face_z;
   logic [2:0]  rsp_face_dir;
   logic [7:0]  rsp_face_block;
   logic [20:0] rsp_base_vertex;
   logic        rsp_last_face;

   // Mirror of the chunk: bit 8 is the active flag, bits 7:0 the block type.
   bit [8:0]            chunk_copy [0:CELLS-1];
   // Cells that have been written at least once; only these may ever be read by the block.
   bit                  cell_written [0:CELLS-1];
   bit [COUNT_BITS-1:0] mesh_face_count;
   face_record_type     pending_faces [$];
   int                  mismatches;
   int                  send_idle_pct;

   voxel_face_culler_core u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .req_cell_z      (req_cell_z),
      .req_cell_active (req_cell_active),
      .req_cell_type   (req_cell_type),
      .req_restart_mesh(req_restart_mesh),
      .rsp_strobe      (rsp_strobe),
      .rsp_face_x      (rsp_face_x),
      .rsp_face_y      (rsp_face_y),
      .rsp_face_z      (rsp_face_z),
      .rsp_face_dir    (rsp_face_dir),
      .rsp_face_block  (rsp_face_block),
      .rsp_base_vertex (rsp_base_vertex),
      .rsp_last_face   (rsp_last_face)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Geometry helpers shared by the face predictor and the stimulus legality check.
   // ---------------------------------------------------------------------------------------

   function automatic bit in_chunk(input int x, input int y, input int z);
      return x >= 0 && x < DEF_CHUNK_WIDTH && y >= 0 && y < DEF_CHUNK_TALL &&
             z >= 0 && z < DEF_CHUNK_WIDTH;
   endfunction

   function automatic int cell_index(input int x, input int y, input int z);
      return (x * DEF_CHUNK_TALL + y) * DEF_CHUNK_WIDTH + z;
   endfunction

   // Offset from a cell to the neighbour that covers the given face.
   function automatic void dir_offset(input face_dir_type dir, output int dx, output int dy,
                                      output int dz);
      dx = 0;
      dy = 0;
      dz = 0;
      case (dir)
         DIR_TOP:    dy = 1;
         DIR_BOTTOM: dy = -1;
         DIR_RIGHT:  dx = 1;
         DIR_LEFT:   dx = -1;
         DIR_FRONT:  dz = 1;
         default:    dz = -1;
      endcase
   endfunction

   // A mesh request is only legal when the block cannot touch a never-written store entry:
   // the cell itself and each of its in-chunk neighbours must have been written.
   function automatic bit mesh_legal(input int x, input int y, input int z);
      int dx, dy, dz;
      bit ok;
      ok = cell_written[cell_index(x, y, z)];
      for (int d = 0; d < NUM_DIRS; d++) begin
         dir_offset(face_dir_type'(d), dx, dy, dz);
         if (in_chunk(x + dx, y + dy, z + dz) && !cell_written[cell_index(x + dx, y + dy, z + dz)])
            ok = 1'b0;
      end
      return ok;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Face predictor. A write updates the chunk mirror. A mesh request optionally clears the
   // face counter, then, for an active cell, queues one record per open face in the fixed
   // top, bottom, right, left, front, back order. A face is open when the neighbour lies
   // outside the chunk or is inactive. The counter wraps at its 19-bit width.
   // ---------------------------------------------------------------------------------------

   function automatic void predict_request(input func_type func, input int x, input int y,
                                           input int z, input bit act, input bit [7:0] typ,
                                           input bit restart);
      face_record_type faces [NUM_DIRS];
      int              n;
      int              dx, dy, dz;
      bit [8:0]        entry;
      bit              open;
      n = 0;
      // Coordinates outside the chunk are ignored by both request kinds.
      if (!in_chunk(x, y, z))
         return;
      if (func == FUNC_WRITE) begin
         chunk_copy[cell_index(x, y, z)]   = {act, typ};
         cell_written[cell_index(x, y, z)] = 1'b1;
         return;
      end
      if (restart)
         mesh_face_count = '0;
      entry = chunk_copy[cell_index(x, y, z)];
      if (!entry[8])
         return;
      for (int d = 0; d < NUM_DIRS; d++) begin
         dir_offset(face_dir_type'(d), dx, dy, dz);
         open = !in_chunk(x + dx, y + dy, z + dz) ||
                !chunk_copy[cell_index(x + dx, y + dy, z + dz)][8];
         if (open) begin
            faces[n].x     = x[3:0];
            faces[n].y     = y[7:0];
            faces[n].z     = z[3:0];
            faces[n].dir   = face_dir_type'(d);
            faces[n].block = entry[7:0];
            faces[n].base  = {mesh_face_count, 2'b00};
            faces[n].last  = 1'b0;
            mesh_face_count = mesh_face_count + 1'b1;
            n++;
         end
      end
      for (int i = 0; i < n; i++) begin
         faces[i].last = (i == n - 1);
         pending_faces.push_back(faces[i]);
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request driver. It is always entered right after a rising edge. It may hold start low
   // for a random number of cycles, then raises start and waits for the edge at which busy
   // is low; that edge accepts the request, and the predictor is updated there. Start is
   // left high on return so that back-to-back requests need no second assignment per step.
   // ---------------------------------------------------------------------------------------

   task automatic send_request(input func_type func, input bit [3:0] x, input bit [7:0] y,
                               input bit [3:0] z, input bit act, input bit [7:0] typ,
                               input bit restart);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_func         <= func;
      req_cell_x       <= x;
      req_cell_y       <= y;
      req_cell_z       <= z;
      req_cell_active  <= act;
      req_cell_type    <= typ;
      req_restart_mesh <= restart;
      do
         @(posedge clock);
      while (busy);
      predict_request(func, x, y, z, act, typ, restart);
   endtask

   // The restart flag rides along at random, since the block must ignore it on writes.
   task automatic write_cell(input int x, input int y, input int z, input bit act,
                             input bit [7:0] typ);
      send_request(FUNC_WRITE, x[3:0], y[7:0], z[3:0], act, typ, $urandom_range(1));
   endtask

   // Active flag and type are don't-care on a mesh request and are randomized.
   task automatic mesh_cell(input int x, input int y, input int z, input bit restart);
      send_request(FUNC_EMIT, x[3:0], y[7:0], z[3:0], $urandom_range(1), $urandom_range(255),
                   restart);
   endtask

   // ---------------------------------------------------------------------------------------
   // Response checker. The block cannot be stalled, so every strobe is one face record that
   // must match the oldest expectation field by field.
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin : check_faces
      face_record_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_faces.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("%0t unexpected face x=%0d y=%0d z=%0d dir=%0d", $realtime,
                        rsp_face_x, rsp_face_y, rsp_face_z, rsp_face_dir);
         end else begin
            want = pending_faces.pop_front();
            if (rsp_face_x !== want.x || rsp_face_y !== want.y || rsp_face_z !== want.z ||
                rsp_face_dir !== want.dir || rsp_face_block !== want.block ||
                rsp_base_vertex !== want.base || rsp_last_face !== want.last) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN) begin
                  $display("%0t expected x=%0d y=%0d z=%0d dir=%0d blk=%0d base=%0d last=%0d",
                           $realtime,
                           want.x, want.y, want.z, want.dir, want.block, want.base, want.last);
                  $display("%0t      got x=%0d y=%0d z=%0d dir=%0d blk=%0d base=%0d last=%0d",
                           $realtime,
                           rsp_face_x, rsp_face_y, rsp_face_z, rsp_face_dir, rsp_face_block,
                           rsp_base_vertex, rsp_last_face);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------------

   // Cells in two opposite chunk corners. The low corner has a mix of active and inactive
   // neighbours, so some faces are culled; the high corner is surrounded by inactive cells
   // and chunk borders and must show all six faces, with the count carried on from before.
   task automatic test_corner_faces();
      write_cell(0, 0, 0, 1'b1, 8'hA5);
      write_cell(1, 0, 0, 1'b1, 8'h00);
      write_cell(0, 1, 0, 1'b0, 8'hFF);
      write_cell(0, 0, 1, 1'b1, 8'h5A);
      mesh_cell(0, 0, 0, 1'b1);
      write_cell(15, 255, 15, 1'b1, 8'hFF);
      write_cell(14, 255, 15, 1'b0, 8'h81);
      write_cell(15, 254, 15, 1'b0, 8'h7E);
      write_cell(15, 255, 14, 1'b0, 8'h00);
      mesh_cell(15, 255, 15, 1'b0);
   endtask

   // An inactive cell emits nothing, and a cell buried among six active neighbours has no
   // visible face. The buried cell is meshed with restart set, which must clear the count
   // even though no face comes out.
   task automatic test_hidden_cells();
      int dx, dy, dz;
      write_cell(15, 254, 14, 1'b1, 8'h3C);
      write_cell(14, 255, 14, 1'b1, 8'hC3);
      write_cell(15, 255, 13, 1'b1, 8'h0F);
      mesh_cell(15, 255, 14, 1'b0);
      write_cell(8, 128, 8, 1'b1, 8'hF0);
      for (int d = 0; d < NUM_DIRS; d++) begin
         dir_offset(face_dir_type'(d), dx, dy, dz);
         write_cell(8 + dx, 128 + dy, 8 + dz, 1'b1, $urandom_range(255));
      end
      mesh_cell(8, 128, 8, 1'b1);
   endtask

   // After the clear above, a write with restart set must not touch the count, and the next
   // mesh requests must number their vertices from zero upward.
   task automatic test_restart_count();
      send_request(FUNC_WRITE, 4'd0, 8'd1, 4'd0, 1'b1, 8'h11, 1'b1);
      mesh_cell(0, 0, 0, 1'b0);
      mesh_cell(15, 255, 15, 1'b0);
   endtask

   // Picks a box origin, biased toward both chunk borders.
   function automatic int pick_origin(input int top);
      int pick;
      pick = $urandom_range(3);
      return pick == 0 ? 0 : pick == 1 ? top : $urandom_range(top);
   endfunction

   // Each round fills a 4 x 3 x 4 box with random cells, then mixes mesh requests on legal
   // cells of the box with rewrites of box cells. The middle cell of the box is always legal,
   // so every mesh request has a fallback; cells made legal by earlier rounds are reused.
   task automatic test_random_chunk(input int idle_pct, input int rounds);
      int ox, oy, oz;
      int mx, my, mz;
      int tries;
      send_idle_pct = idle_pct;
      for (int r = 0; r < rounds; r++) begin
         ox = pick_origin(DEF_CHUNK_WIDTH - 4);
         oy = pick_origin(DEF_CHUNK_TALL - 3);
         oz = pick_origin(DEF_CHUNK_WIDTH - 4);
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 3; j++)
               for (int k = 0; k < 4; k++)
                  write_cell(ox + i, oy + j, oz + k, $urandom_range(9) < 7, $urandom_range(255));
         for (int n = 0; n < 36; n++) begin
            mx = ox + $urandom_range(3);
            my = oy + $urandom_range(2);
            mz = oz + $urandom_range(3);
            if ($urandom_range(3) == 0) begin
               write_cell(mx, my, mz, $urandom_range(9) < 7, $urandom_range(255));
            end else begin
               tries = 0;
               while (!mesh_legal(mx, my, mz) && tries < 8) begin
                  mx = ox + $urandom_range(3);
                  my = oy + $urandom_range(2);
                  mz = oz + $urandom_range(3);
                  tries++;
               end
               if (!mesh_legal(mx, my, mz)) begin
                  mx = ox + 1;
                  my = oy + 1;
                  mz = oz + 1;
               end
               mesh_cell(mx, my, mz, $urandom_range(9) == 0);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence: reset once, directed tests, three random phases with the sender idling in a
   // quarter of the cycles, then in most of them, then never. Finally drain the expected
   // faces and give the block time to show anything stray.
   // ---------------------------------------------------------------------------------------

   initial begin
      mismatches       = 0;
      mesh_face_count  = '0;
      send_idle_pct    = 25;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_func         <= FUNC_WRITE;
      req_cell_x       <= '0;
      req_cell_y       <= '0;
      req_cell_z       <= '0;
      req_cell_active  <= 1'b0;
      req_cell_type    <= '0;
      req_restart_mesh <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_corner_faces();
      test_hidden_cells();
      test_restart_count();
      test_random_chunk(25, 2);
      test_random_chunk(71, 2);
      test_random_chunk(0, 2);

      start <= 1'b0;
      while (pending_faces.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);

      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of about 530 requests.
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/vfc_pkg.sv
hw/rtl/vfc_cell_mem.sv
hw/rtl/vfc_mesh_ctrl.sv
hw/rtl/voxel_face_culler_core.sv
tb/tb.sv
